// ===== sv/sctf_pkg.sv =====
// Shared widths and fixed-point constants for the Taylor sine/cosine pipeline.
`default_nettype none

package sctf_pkg;

    // Default count of fractional bits on the angle and the result
    localparam int FRAC_BITS_DEF = 16;

    // Fixed port widths
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 18;

    // Range reduction constants, Q32
    localparam logic signed [35:0] HALF_PI_Q32     = 36'sd6746518852;
    localparam logic signed [35:0] TWO_HALF_PI_Q32 = 36'sd13493037704;
    localparam logic signed [35:0] PI_Q32          = 36'sd13493037705;
    localparam logic [17:0]        PI_LO           = PI_Q32[17:0];
    localparam logic [15:0]        PI_HI           = PI_Q32[33:18];

    // floor(2^64 / PI_Q32), used to estimate the count of half turns
    localparam logic [30:0] RECIP_PI = 31'd1367130551;

    // Small-angle threshold 0.3, Q32
    localparam logic [33:0] SMALL_Q32 = 34'd1288490189;

    // Polynomial constants, Q28
    localparam logic signed [31:0] ONE_Q28   = 32'sd268435456;
    localparam logic [25:0]        SIXTH_Q28 = 26'd44739243;
    localparam logic [21:0]        C120_Q28  = 22'd2236962;
    localparam logic signed [32:0] SNAP_Q28  = 33'sd1207960;

endpackage

`default_nettype wire

// ===== sv/sine_cosine_taylor_fixed_unit.sv =====
// Top level: fully pipelined fifth-order Taylor sine/cosine unit.
//
// Takes one angle beat per cycle and returns one value beat per cycle while the
// output is not stalled; each result passes through 15 register stages, the
// first loaded at the edge that accepts its angle. The depth is set by
// the range reduction (a reciprocal multiply that estimates the count of
// half turns, two partial products of that count by pi, and a one-step
// correction) followed by the polynomial chain, which puts one multiplier
// in each stage. A stall on the output freezes every stage at once, so the
// input stalls only while a finished value waits to be taken. Cosine is the
// sine of the angle plus pi/2; reduced angles below 0.3 pass straight
// through, larger ones go through r - r^3/6 + r^5/120 with a snap to 1.
`default_nettype none

module sine_cosine_taylor_fixed_unit
    import sctf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_kind,
    input  wire logic signed [ANGLE_W-1:0]  i_angle,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [VALUE_W-1:0]       o_value
);

    // Derived widths
    localparam int NS    = 15;                // register stages
    localparam int SH    = 32 - FRAC_BITS;    // angle to Q32 shift
    localparam int A_W   = 65 - FRAC_BITS;    // Q32 angle width
    localparam int T_W   = A_W - 32;          // integer part, half-turn count
    localparam int PL_W  = T_W + 19;
    localparam int PH_W  = T_W + 17;
    localparam int PS    = 28 - FRAC_BITS;    // Q28 to output shift
    localparam int RES_W = FRAC_BITS + 3;

    localparam logic signed [35:0] PI_TWICE = PI_Q32 <<< 1;
    localparam logic signed [35:0] PI_NEG   = -PI_Q32;
    localparam logic signed [33:0] HP_POS   = HALF_PI_Q32[33:0];
    localparam logic signed [33:0] HP_NEG   = -HP_POS;
    localparam logic signed [34:0] SR_HALF  = 35'sd1 <<< (SH - 1);
    localparam logic signed [32:0] PR_HALF  = 33'sd1 <<< (PS - 1);
    localparam logic signed [63:0] RND28    = 64'sd1 <<< 27;
    localparam logic signed [32:0] ONE_W    = 33'(ONE_Q28);
    localparam logic signed [32:0] SNAP_NEG = -SNAP_Q28;

    // Stage valid bits and global advance
    logic [NS-1:0] r_vld;
    logic          adv;

    assign o_stall = r_vld[NS-1] & i_stall;
    assign adv     = ~o_stall;
    assign o_valid = r_vld[NS-1];

    // Pipeline registers
    logic                     r_kind;
    logic signed [31:0]       r_angle;
    logic signed [A_W-1:0]    r_y1;
    logic signed [A_W-1:0]    r_y2;
    logic signed [T_W-1:0]    r_qhat;
    logic signed [PL_W-1:0]   r_plo;
    logic signed [PH_W-1:0]   r_phi;
    logic [35:0]              r_ylo;
    logic                     r_q0_3;
    logic                     r_q0_4;
    logic signed [35:0]       r_rem;
    logic signed [33:0]       r_ared;
    logic                     r_odd   [5:13];
    logic                     r_small [6:13];
    logic signed [RES_W-1:0]  r_sres  [6:13];
    logic signed [29:0]       r_rr    [6:11];
    logic signed [30:0]       r_x2_7;
    logic signed [30:0]       r_x2_8;
    logic signed [30:0]       r_x3_8;
    logic signed [30:0]       r_x3_9;
    logic signed [32:0]       r_x5_9;
    logic signed [32:0]       r_x5_10;
    logic signed [30:0]       r_t3_10;
    logic signed [30:0]       r_t3_11;
    logic signed [30:0]       r_t5_11;
    logic signed [31:0]       r_s;
    logic signed [RES_W-1:0]  r_pres;
    logic signed [VALUE_W-1:0] r_value;

    // Next values
    logic signed [A_W-1:0]    n_y;
    logic signed [T_W-1:0]    n_t;
    logic signed [T_W+31:0]   n_qprod;
    logic signed [T_W-1:0]    n_qhat;
    logic signed [PL_W-1:0]   n_plo;
    logic signed [PH_W-1:0]   n_phi;
    logic signed [35:0]       n_rem;
    logic signed [35:0]       n_ared_w;
    logic                     n_fix;
    logic [33:0]              n_abs;
    logic                     n_small;
    logic signed [34:0]       n_srnd;
    logic signed [34:0]       n_rrnd;
    logic signed [59:0]       n_p2;
    logic signed [60:0]       n_p3;
    logic signed [61:0]       n_p5;
    logic signed [57:0]       n_p6;
    logic signed [55:0]       n_p7;
    logic signed [63:0]       n_p2r;
    logic signed [63:0]       n_p3r;
    logic signed [63:0]       n_p5r;
    logic signed [63:0]       n_p6r;
    logic signed [63:0]       n_p7r;
    logic signed [31:0]       n_s;
    logic signed [32:0]       n_d;
    logic signed [31:0]       n_ssel;
    logic signed [32:0]       n_prnd;
    logic signed [RES_W-1:0]  n_res;
    logic signed [RES_W-1:0]  n_sres;
    logic signed [29:0]       n_r;

    // Scale to Q32, add pi/2 for cosine and pi/2 for the floor offset
    always_comb begin
        n_y = (A_W'(r_angle) <<< SH)
            + (r_kind ? A_W'(TWO_HALF_PI_Q32) : A_W'(HALF_PI_Q32));
    end

    // Estimate the half-turn count from the integer part
    always_comb begin
        n_t     = $signed(r_y1[A_W-1:32]);
        n_qprod = n_t * $signed({1'b0, RECIP_PI});
        n_qhat  = $signed(n_qprod[T_W+31:32]);
    end

    // Multiply the estimate by pi in two halves
    always_comb begin
        n_plo = r_qhat * $signed({1'b0, PI_LO});
        n_phi = r_qhat * $signed({1'b0, PI_HI});
    end

    // Remainder after the estimate, exact in 36 bits
    always_comb begin
        n_rem = $signed(r_ylo) - 36'(r_plo) - (36'(r_phi) <<< 18);
    end

    // Correct the estimate by one step and remove the offset
    always_comb begin
        n_fix = 1'b1;
        priority if (r_rem < 36'sd0) begin
            n_ared_w = r_rem + PI_Q32 - HALF_PI_Q32;
        end else if (r_rem >= PI_Q32) begin
            n_ared_w = r_rem - PI_Q32 - HALF_PI_Q32;
        end else begin
            n_ared_w = r_rem - HALF_PI_Q32;
            n_fix    = 1'b0;
        end
    end

    // Small-angle test, direct result and Q28 angle
    always_comb begin
        n_abs   = r_ared[33] ? 34'(-r_ared) : 34'(r_ared);
        n_small = n_abs < SMALL_Q32;
        n_srnd  = 35'(r_ared) + SR_HALF;
        n_sres  = n_srnd[34:SH];
        n_rrnd  = 35'(r_ared) + 35'sd8;
        n_r     = n_rrnd[33:4];
    end

    // Polynomial products, one per stage, each rounded back to Q28
    always_comb begin
        n_p2  = r_rr[6] * r_rr[6];
        n_p2r = 64'(n_p2) + RND28;
        n_p3  = r_x2_7 * r_rr[7];
        n_p3r = 64'(n_p3) + RND28;
        n_p5  = r_x2_8 * r_x3_8;
        n_p5r = 64'(n_p5) + RND28;
        n_p6  = r_x3_9 * $signed({1'b0, SIXTH_Q28});
        n_p6r = 64'(n_p6) + RND28;
        n_p7  = r_x5_10 * $signed({1'b0, C120_Q28});
        n_p7r = 64'(n_p7) + RND28;
    end

    // Sum the series
    always_comb begin
        n_s = 32'(r_rr[11]) - 32'(r_t3_11) + 32'(r_t5_11);
    end

    // Snap near one and round to the output format
    always_comb begin
        n_d    = 33'(r_s) - ONE_W;
        n_ssel = (n_d > SNAP_NEG && n_d < SNAP_Q28) ? ONE_Q28 : r_s;
        n_prnd = 33'(n_ssel) + PR_HALF;
    end

    // Pick the path and flip the sign on odd half turns
    always_comb begin
        n_res = r_small[13] ? r_sres[13] : r_pres;
        if (r_odd[13]) begin
            n_res = -n_res;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // Advance payload; hold everything while the output beat stalls
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind   <= i_kind;
            r_angle  <= i_angle;
            r_y1     <= n_y;
            r_y2     <= r_y1;
            r_qhat   <= n_qhat;
            r_plo    <= n_plo;
            r_phi    <= n_phi;
            r_ylo    <= r_y2[35:0];
            r_q0_3   <= r_qhat[0];
            r_rem    <= n_rem;
            r_q0_4   <= r_q0_3;
            r_ared   <= n_ared_w[33:0];
            r_odd[5] <= r_q0_4 ^ n_fix;
            for (int i = 6; i <= 13; i++) begin
                r_odd[i] <= r_odd[i-1];
            end
            r_small[6] <= n_small;
            r_sres[6]  <= n_sres;
            for (int i = 7; i <= 13; i++) begin
                r_small[i] <= r_small[i-1];
                r_sres[i]  <= r_sres[i-1];
            end
            r_rr[6] <= n_r;
            for (int i = 7; i <= 11; i++) begin
                r_rr[i] <= r_rr[i-1];
            end
            r_x2_7  <= n_p2r[58:28];
            r_x2_8  <= r_x2_7;
            r_x3_8  <= n_p3r[58:28];
            r_x3_9  <= r_x3_8;
            r_x5_9  <= n_p5r[60:28];
            r_x5_10 <= r_x5_9;
            r_t3_10 <= n_p6r[58:28];
            r_t3_11 <= r_t3_10;
            r_t5_11 <= n_p7r[58:28];
            r_s     <= n_s;
            r_pres  <= n_prnd[PS+RES_W-1:PS];
            r_value <= VALUE_W'(n_res);
        end
    end

    assign o_value = r_value;

    // An accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    // A stalled output freezes every stage
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while the output stalled");

    // The reciprocal estimate is off by at most one half turn
    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_rem >= PI_NEG && r_rem < PI_TWICE))
        else $error("half-turn estimate out of range");

    // The reduced angle lies within plus or minus pi/2
    a_ared_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_ared >= HP_NEG && r_ared <= HP_POS))
        else $error("reduced angle out of range");

endmodule

`default_nettype wire
